>>> design/gtt_pkg.sv
// Shared types, codes and byte classes for the grammar text tokenizer.
`default_nettype none

package gtt_pkg;

    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    localparam logic [3:0] K_SPACE   = 4'd0;
    localparam logic [3:0] K_NEWLINE = 4'd1;
    localparam logic [3:0] K_IDENT   = 4'd2;
    localparam logic [3:0] K_NUMBER  = 4'd3;
    localparam logic [3:0] K_COLON   = 4'd4;
    localparam logic [3:0] K_SEMI    = 4'd5;
    localparam logic [3:0] K_EQU     = 4'd6;
    localparam logic [3:0] K_LBRACE  = 4'd7;
    localparam logic [3:0] K_RBRACE  = 4'd8;
    localparam logic [3:0] K_CHAR    = 4'd9;
    localparam logic [3:0] K_STRING  = 4'd10;
    localparam logic [3:0] K_COMMENT = 4'd11;
    localparam logic [3:0] K_END     = 4'd12;
    localparam logic [3:0] K_ERROR   = 4'd13;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_VTAB       = 8'h0B;
    localparam logic [7:0] CH_FFEED      = 8'h0C;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SPACE   = 4'd1,
        M_CR      = 4'd2,
        M_IDENT   = 4'd3,
        M_NUMBER  = 4'd4,
        M_CHAR    = 4'd5,
        M_STRING  = 4'd6,
        M_SLASH   = 4'd7,
        M_COMMENT = 4'd8
    } mode_t;

    typedef struct packed {
        logic [3:0]          kind;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] length;
        logic                last;
    } tok_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VTAB || c == CH_FFEED;
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

`default_nettype wire

>>> design/grammar_text_tokenizer.sv
// Top level of the byte-stream tokenizer: input register, lexer and result queue.
//
//  channel | direction | handshake            | beat payload
//  in      | in        | in_valid / in_stall  | command, data_byte
//  out     | out       | out_valid / out_stall| token_kind, token_start, token_length,
//          |           |                      | last_of_item
//
// One input beat per cycle while in_stall is low; a byte that closes one token
// and emits another yields two results, absorbed by the four-entry result queue.
// A beat passes through the input register, then the queue, before its first result.
// Reset clears lexer state, stream offset and queue; no clearing pass.
// in_stall rises only while the input register holds a beat and the queue has
// fewer than two free entries; out_stall holds the head result in place.
`default_nettype none

module grammar_text_tokenizer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           command,
    input  wire logic [7:0]     data_byte,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [3:0]          token_kind,
    output logic [31:0]         token_start,
    output logic [15:0]         token_length,
    output logic                last_of_item
);

    logic           in_v_reg;
    logic           cmd_reg;
    logic [7:0]     byte_reg;
    logic           room;
    logic           advance;
    logic [1:0]     res_count;
    logic [1:0]     push_count;
    gtt_pkg::tok_t  res0, res1, head;

    assign advance    = in_v_reg && room;
    assign in_stall   = in_v_reg && !room;
    assign push_count = advance ? res_count : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg  <= command;
            byte_reg <= data_byte;
        end
    end

    gtt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .command   (cmd_reg),
        .data_byte (byte_reg),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    gtt_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = 32'(head.start);
    assign token_length = 16'(head.length);
    assign last_of_item = head.last;

endmodule

`default_nettype wire

>>> design/gtt_lexer.sv
// Lexer state and combinational token decision for one beat.
`default_nettype none

module gtt_lexer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          command,
    input  wire logic [7:0]    data_byte,
    output logic [1:0]         res_count,
    output gtt_pkg::tok_t      res0,
    output gtt_pkg::tok_t      res1
);

    gtt_pkg::mode_t                 mode_reg, mode_next;
    logic                           esc_reg, esc_next;
    logic [gtt_pkg::POS_BITS-1:0]   start_reg, start_next;
    logic [gtt_pkg::LEN_BITS-1:0]   len_reg, len_next;
    logic [gtt_pkg::POS_BITS-1:0]   pos_reg, pos_next;

    gtt_pkg::mode_t                 b_mode;
    logic                           b_emit;
    logic [3:0]                     b_kind;
    logic                           close_en, begin_en, grow_en, end_en, tail_en;
    logic [3:0]                     close_kind, flush_kind;
    logic [7:0]                     quote;
    logic [gtt_pkg::LEN_BITS-1:0]   len_g;
    gtt_pkg::tok_t                  close_tok, tail_tok;

    always_comb
    begin
        b_mode = gtt_pkg::M_IDLE;
        b_emit = 1'b0;
        b_kind = gtt_pkg::K_ERROR;
        if (gtt_pkg::is_blank(data_byte))
        begin
            b_mode = gtt_pkg::M_SPACE;
        end
        else if (data_byte == gtt_pkg::CH_CR)
        begin
            b_mode = gtt_pkg::M_CR;
        end
        else if (data_byte == gtt_pkg::CH_LF)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_NEWLINE;
        end
        else if (gtt_pkg::is_alpha(data_byte))
        begin
            b_mode = gtt_pkg::M_IDENT;
        end
        else if (gtt_pkg::is_digit(data_byte))
        begin
            b_mode = gtt_pkg::M_NUMBER;
        end
        else if (data_byte == gtt_pkg::CH_COLON)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_COLON;
        end
        else if (data_byte == gtt_pkg::CH_SEMI)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_SEMI;
        end
        else if (data_byte == gtt_pkg::CH_EQUALS)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_EQU;
        end
        else if (data_byte == gtt_pkg::CH_LBRACE)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_LBRACE;
        end
        else if (data_byte == gtt_pkg::CH_RBRACE)
        begin
            b_emit = 1'b1;
            b_kind = gtt_pkg::K_RBRACE;
        end
        else if (data_byte == gtt_pkg::CH_SQUOTE)
        begin
            b_mode = gtt_pkg::M_CHAR;
        end
        else if (data_byte == gtt_pkg::CH_DQUOTE)
        begin
            b_mode = gtt_pkg::M_STRING;
        end
        else if (data_byte == gtt_pkg::CH_SLASH)
        begin
            b_mode = gtt_pkg::M_SLASH;
        end
        else
        begin
            b_emit = 1'b1;
        end
    end

    always_comb
    begin
        case (mode_reg)
            gtt_pkg::M_SPACE:   flush_kind = gtt_pkg::K_SPACE;
            gtt_pkg::M_CR:      flush_kind = gtt_pkg::K_NEWLINE;
            gtt_pkg::M_IDENT:   flush_kind = gtt_pkg::K_IDENT;
            gtt_pkg::M_NUMBER:  flush_kind = gtt_pkg::K_NUMBER;
            gtt_pkg::M_COMMENT: flush_kind = gtt_pkg::K_COMMENT;
            default:            flush_kind = gtt_pkg::K_ERROR;
        endcase
    end

    assign quote = (mode_reg == gtt_pkg::M_CHAR) ? gtt_pkg::CH_SQUOTE : gtt_pkg::CH_DQUOTE;

    always_comb
    begin
        close_en   = 1'b0;
        close_kind = gtt_pkg::K_ERROR;
        begin_en   = 1'b0;
        grow_en    = 1'b0;
        end_en     = 1'b0;
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        if (command)
        begin
            close_en   = (mode_reg != gtt_pkg::M_IDLE);
            close_kind = flush_kind;
            end_en     = 1'b1;
        end
        else
        begin
            case (mode_reg)
                gtt_pkg::M_SPACE:
                begin
                    if (gtt_pkg::is_blank(data_byte))
                    begin
                        grow_en = 1'b1;
                    end
                    else
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_SPACE;
                        begin_en   = 1'b1;
                    end
                end
                gtt_pkg::M_CR:
                begin
                    close_en   = 1'b1;
                    close_kind = gtt_pkg::K_NEWLINE;
                    if (data_byte == gtt_pkg::CH_LF)
                    begin
                        grow_en = 1'b1;
                    end
                    else
                    begin
                        begin_en = 1'b1;
                    end
                end
                gtt_pkg::M_IDENT:
                begin
                    if (gtt_pkg::is_alpha(data_byte) || gtt_pkg::is_digit(data_byte)
                        || data_byte == gtt_pkg::CH_MINUS)
                    begin
                        grow_en = 1'b1;
                    end
                    else
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_IDENT;
                        begin_en   = 1'b1;
                    end
                end
                gtt_pkg::M_NUMBER:
                begin
                    if (gtt_pkg::is_digit(data_byte))
                    begin
                        grow_en = 1'b1;
                    end
                    else
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_NUMBER;
                        begin_en   = 1'b1;
                    end
                end
                gtt_pkg::M_CHAR, gtt_pkg::M_STRING:
                begin
                    if (data_byte == quote && !esc_reg)
                    begin
                        grow_en    = 1'b1;
                        close_en   = 1'b1;
                        close_kind = (mode_reg == gtt_pkg::M_CHAR) ? gtt_pkg::K_CHAR
                                                                   : gtt_pkg::K_STRING;
                    end
                    else if (gtt_pkg::is_newline(data_byte))
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_ERROR;
                        begin_en   = 1'b1;
                    end
                    else
                    begin
                        grow_en  = 1'b1;
                        esc_next = (data_byte == gtt_pkg::CH_BACKSLASH) && !esc_reg;
                    end
                end
                gtt_pkg::M_SLASH:
                begin
                    if (data_byte == gtt_pkg::CH_SLASH)
                    begin
                        grow_en   = 1'b1;
                        mode_next = gtt_pkg::M_COMMENT;
                    end
                    else
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_ERROR;
                        begin_en   = 1'b1;
                    end
                end
                gtt_pkg::M_COMMENT:
                begin
                    if (gtt_pkg::is_newline(data_byte))
                    begin
                        close_en   = 1'b1;
                        close_kind = gtt_pkg::K_COMMENT;
                        begin_en   = 1'b1;
                    end
                    else
                    begin
                        grow_en = 1'b1;
                    end
                end
                default:
                begin
                    begin_en = 1'b1;
                end
            endcase
        end

        len_g = (grow_en && len_reg < gtt_pkg::LEN_MAX)
              ? len_reg + gtt_pkg::LEN_BITS'(1) : len_reg;
        start_next = start_reg;
        len_next   = len_g;
        if (close_en || end_en)
        begin
            mode_next = gtt_pkg::M_IDLE;
            esc_next  = 1'b0;
        end
        if (begin_en)
        begin
            mode_next  = b_mode;
            esc_next   = 1'b0;
            start_next = pos_reg;
            len_next   = gtt_pkg::LEN_BITS'(1);
        end
        pos_next = end_en ? '0 : pos_reg + gtt_pkg::POS_BITS'(1);
    end

    always_comb
    begin
        tail_en = (begin_en && b_emit) || end_en;

        close_tok.kind   = close_kind;
        close_tok.start  = start_reg;
        close_tok.length = len_g;
        close_tok.last   = !tail_en;

        tail_tok.kind    = end_en ? gtt_pkg::K_END : b_kind;
        tail_tok.start   = pos_reg;
        tail_tok.length  = end_en ? '0 : gtt_pkg::LEN_BITS'(1);
        tail_tok.last    = 1'b1;

        res_count = {1'b0, close_en} + {1'b0, tail_en};
        res0      = close_en ? close_tok : tail_tok;
        res1      = tail_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= gtt_pkg::M_IDLE;
            esc_reg   <= 1'b0;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            esc_reg   <= esc_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> design/gtt_out_fifo.sv
// Four-entry result queue taking up to two tokens per cycle and giving one per cycle while out_stall is low.
`default_nettype none

module gtt_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [1:0]     push_count,
    input  wire gtt_pkg::tok_t  push0,
    input  wire gtt_pkg::tok_t  push1,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_stall,
    output gtt_pkg::tok_t       head
);

    gtt_pkg::tok_t  entry_reg [4];
    logic [1:0]     wr_reg, wr_next;
    logic [1:0]     rd_reg, rd_next;
    logic [2:0]     count_reg, count_next;
    logic           pop;

    assign out_valid = (count_reg != 3'd0);
    assign room      = (count_reg < 3'd3);
    assign head      = entry_reg[rd_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_next    = wr_reg + push_count;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push_count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
